### rtl/hpq_pkg.sv
// Shared types, constants and helper functions of the heap priority queue.
`default_nettype none

package hpq_pkg;

    // Number of entries the heap can hold.
    localparam int CAPACITY = 1024;
    // Slot address width and width of a count or a 1-based heap position.
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // Width of a child position, which can reach twice the capacity.
    localparam int POS_W    = CNT_W + 1;

    localparam int ID_W     = 16;
    localparam int PRICE_W  = 32;
    localparam int ENTRY_W  = ID_W + PRICE_W;

    typedef enum logic {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } hpq_kind_t;

    typedef enum logic [1:0] {
        STAT_PUSHED = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_POPPED = 2'd2,
        STAT_EMPTY  = 2'd3
    } hpq_status_t;

    // One heap entry; the id sits in the low bits.
    typedef struct packed {
        logic signed [PRICE_W-1:0] price;
        logic [ID_W-1:0]           id;
    } hpq_entry_t;

    // Result of one operation as it leaves the heap engine.
    typedef struct packed {
        logic        valid;
        hpq_status_t status;
        hpq_entry_t  entry;
    } hpq_result_t;

    // Result as it waits in the output buffer.
    typedef struct packed {
        hpq_status_t status;
        hpq_entry_t  entry;
    } hpq_out_t;

    // Controller states of the heap engine.
    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CMP,
        S_POP_ROOT,
        S_POP_LAST,
        S_DN_RDR,
        S_DN_CMP,
        S_WR_E
    } hpq_state_t;

    // True when entry a is served before entry b: lower price, then higher id.
    function automatic logic better(hpq_entry_t a, hpq_entry_t b);
        logic lt;
        logic eq;
        lt = a.price < b.price;
        eq = a.price == b.price;
        return lt || (eq && (a.id > b.id));
    endfunction

    // Memory slot of a 1-based heap position.
    function automatic logic [ADDR_W-1:0] slot_of(logic [POS_W-1:0] pos);
        logic [POS_W-1:0] s;
        s = pos - 1'b1;
        return s[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/priority_min_heap_queue.sv
// Top level of the heap priority queue: store, heap engine and output buffer.
//
// A bounded binary min-heap of (id, price) entries with room for 1024 entries.
// The input channel s_* takes one operation per item: tuser carries the kind
// (0 push, 1 pop), tdata the id and price of a pushed entry. Every item gives
// exactly one result item on m_*: tuser carries the status (0 pushed, 1 full
// and dropped, 2 popped, 3 empty), tdata the popped id and price, zero for
// any other status. The heap lives in one memory with a registered read port.
// A push result enters the output buffer when the push is accepted; a pop
// result enters it once the root has been read. A push then keeps the engine
// busy while the entry climbs, one memory read per level; a pop moves the
// last entry to the root and lets it sink, two reads per level for the
// children, until it reaches a leaf or a compare stops it above the leaves.
// A full push or an empty pop leaves the engine idle.
// Operations are handled one at a time; the next item is taken as soon as the
// engine is free. Reset clears the entry count, so the heap is empty at once;
// no memory clearing pass runs. A two-item output buffer holds results while
// the receiver stalls; when both places are taken, s_tready stays low.
`default_nettype none

module priority_min_heap_queue (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // item_id [15:0], item_price [47:16]
    input  wire logic        s_tuser,   // kind [0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,   // out_id [15:0], out_price [47:16]
    output logic      [1:0]  m_tuser    // status [1:0]
);

    import hpq_pkg::*;

    hpq_result_t       res;
    hpq_entry_t        op_entry;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    hpq_entry_t        ram_wdata;
    hpq_entry_t        ram_rdata;

    hpq_out_t          ob0_reg, ob0_next;
    hpq_out_t          ob1_reg, ob1_next;
    logic [1:0]        ob_cnt_reg, ob_cnt_next;
    hpq_out_t          res_out;
    logic              enq;
    logic              deq;

    assign op_entry.id    = s_tdata[ID_W-1:0];
    assign op_entry.price = $signed(s_tdata[ENTRY_W-1:ID_W]);

    hpq_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (s_tvalid),
        .op_ready  (s_tready),
        .op_kind   (hpq_kind_t'(s_tuser)),
        .op_entry  (op_entry),
        .res_space (ob_cnt_reg != 2'd2),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    hpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Two-place output buffer; the head drives the master side.
    assign res_out.status = res.status;
    assign res_out.entry  = res.entry;
    assign enq            = res.valid;
    assign deq            = m_tvalid && m_tready;

    assign m_tvalid = ob_cnt_reg != 2'd0;
    assign m_tdata  = ob0_reg.entry;
    assign m_tuser  = ob0_reg.status;

    always_comb
    begin
        ob0_next    = ob0_reg;
        ob1_next    = ob1_reg;
        ob_cnt_next = ob_cnt_reg;
        unique case ({enq, deq})
            2'b10:
            begin
                if (ob_cnt_reg == 2'd0)
                begin
                    ob0_next = res_out;
                end
                else
                begin
                    ob1_next = res_out;
                end
                ob_cnt_next = ob_cnt_reg + 2'd1;
            end
            2'b01:
            begin
                ob0_next    = ob1_reg;
                ob_cnt_next = ob_cnt_reg - 2'd1;
            end
            2'b11:
            begin
                if (ob_cnt_reg == 2'd1)
                begin
                    ob0_next = res_out;
                end
                else
                begin
                    ob0_next = ob1_reg;
                    ob1_next = res_out;
                end
            end
            default:
            begin
                ob_cnt_next = ob_cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_cnt_reg <= 2'd0;
        end
        else
        begin
            ob_cnt_reg <= ob_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ob0_reg <= ob0_next;
        ob1_reg <= ob1_next;
    end

endmodule

`default_nettype wire

### rtl/hpq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module hpq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port; a read issued after the write sees the new data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/hpq_core.sv
// Heap engine: accepts push and pop operations and sifts entries through the store.
`default_nettype none

module hpq_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // Operation channel.
    input  wire logic                op_valid,
    output logic                     op_ready,
    input  wire hpq_pkg::hpq_kind_t  op_kind,
    input  wire hpq_pkg::hpq_entry_t op_entry,
    // Room in the output buffer for one more result.
    input  wire logic                res_space,
    output hpq_pkg::hpq_result_t     res,
    // Store port.
    output logic                     ram_we,
    output logic [hpq_pkg::ADDR_W-1:0] ram_waddr,
    output hpq_pkg::hpq_entry_t      ram_wdata,
    output logic [hpq_pkg::ADDR_W-1:0] ram_raddr,
    input  wire hpq_pkg::hpq_entry_t ram_rdata
);

    import hpq_pkg::*;

    hpq_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    hpq_entry_t       ent_reg, ent_next;
    hpq_entry_t       left_reg, left_next;
    logic             rvalid_reg, rvalid_next;

    logic             accept;
    logic [POS_W-1:0] cnt_w;
    logic [POS_W-1:0] pos_w;
    logic [POS_W-1:0] left_pos;
    logic [POS_W-1:0] right_pos;
    logic [CNT_W-1:0] push_pos;
    logic [CNT_W-1:0] par_pos;
    logic             take_left;
    logic             take_right;
    hpq_entry_t       best_ent;
    logic [POS_W-1:0] child_pos;
    logic [CNT_W-1:0] child_n;
    logic [POS_W-1:0] grand_pos;

    assign op_ready  = (state_reg == S_IDLE) && res_space;
    assign accept    = op_valid && op_ready;

    // Position arithmetic shared by the states.
    assign cnt_w     = {1'b0, count_reg};
    assign pos_w     = {1'b0, pos_reg};
    assign left_pos  = {pos_reg, 1'b0};
    assign right_pos = {pos_reg, 1'b1};
    assign push_pos  = count_reg + 1'b1;
    assign par_pos   = pos_reg >> 1;

    // Child selection of one sift-down level, in the order of the tie rule.
    assign take_left  = better(left_reg, ent_reg);
    assign best_ent   = take_left ? left_reg : ent_reg;
    assign take_right = rvalid_reg && better(ram_rdata, best_ent);
    assign child_pos  = take_right ? right_pos : left_pos;
    assign child_n    = child_pos[CNT_W-1:0];
    assign grand_pos  = {child_n, 1'b0};

    // Controller state and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        ent_reg    <= ent_next;
        left_reg   <= left_next;
        rvalid_reg <= rvalid_next;
    end

    // Next state, store accesses and results.
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        ent_next     = ent_reg;
        left_next    = left_reg;
        rvalid_next  = rvalid_reg;
        ram_we       = 1'b0;
        ram_waddr    = slot_of(pos_w);
        ram_wdata    = ent_reg;
        ram_raddr    = '0;
        res          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res.valid = 1'b1;
                    if (op_kind == KIND_PUSH)
                    begin
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            res.status = STAT_FULL;
                        end
                        else
                        begin
                            // New entry starts at the end and climbs toward the root.
                            res.status = STAT_PUSHED;
                            count_next = push_pos;
                            pos_next   = push_pos;
                            ent_next   = op_entry;
                            ram_raddr  = slot_of({1'b0, push_pos >> 1});
                            if (count_reg != '0)
                            begin
                                state_next = S_UP_CMP;
                            end
                            else
                            begin
                                state_next = S_WR_E;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res.status = STAT_EMPTY;
                        end
                        else
                        begin
                            // The popped root is reported once it has been read.
                            res.valid  = 1'b0;
                            state_next = S_POP_ROOT;
                        end
                    end
                end
            end

            S_UP_CMP:
            begin
                // The parent is on the read port; move it down if the new entry wins.
                ram_we = 1'b1;
                if (better(ent_reg, ram_rdata))
                begin
                    ram_wdata = ram_rdata;
                    pos_next  = par_pos;
                    ram_raddr = slot_of({1'b0, par_pos >> 1});
                    if (par_pos > CNT_W'(1))
                    begin
                        state_next = S_UP_CMP;
                    end
                    else
                    begin
                        state_next = S_WR_E;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_POP_ROOT:
            begin
                // Report the root and fetch the last entry to take its place.
                res.valid    = 1'b1;
                res.status   = STAT_POPPED;
                res.entry    = ram_rdata;
                ram_raddr    = slot_of(cnt_w);
                count_next   = count_reg - 1'b1;
                state_next   = S_POP_LAST;
            end

            S_POP_LAST:
            begin
                ent_next  = ram_rdata;
                pos_next  = CNT_W'(1);
                ram_raddr = slot_of(POS_W'(2));
                if (count_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else if (count_reg == CNT_W'(1))
                begin
                    state_next = S_WR_E;
                end
                else
                begin
                    state_next = S_DN_RDR;
                end
            end

            S_DN_RDR:
            begin
                // Left child arrives; fetch the right child if it exists.
                left_next   = ram_rdata;
                rvalid_next = right_pos <= cnt_w;
                ram_raddr   = slot_of(right_pos);
                state_next  = S_DN_CMP;
            end

            S_DN_CMP:
            begin
                ram_we = 1'b1;
                if (take_left || take_right)
                begin
                    // A child moves up into the hole and the hole moves down.
                    ram_wdata = take_right ? ram_rdata : left_reg;
                    pos_next  = child_n;
                    ram_raddr = slot_of(grand_pos);
                    if (grand_pos <= cnt_w)
                    begin
                        state_next = S_DN_RDR;
                    end
                    else
                    begin
                        state_next = S_WR_E;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_WR_E:
            begin
                // Place the sifted entry in its final slot.
                ram_we     = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/hpq_checker.sv
// Port-level checker of the heap priority queue and its bind to the top level.
`default_nettype none

module hpq_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    import hpq_pkg::*;

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

    // Only a popped result carries an entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != STAT_POPPED) |-> m_tdata == '0)
    else $error("non-pop result with nonzero payload");

    // A push into an empty output answers in the next cycle with a push status.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == KIND_PUSH) && !m_tvalid
        |=> m_tvalid && ((m_tuser == STAT_PUSHED) || (m_tuser == STAT_FULL)))
    else $error("push result missing or wrong");

    // An empty pop answers in the next cycle, a real pop only after the root has been read in S_POP_ROOT.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == KIND_POP) && !m_tvalid
        |=> (m_tvalid && (m_tuser == STAT_EMPTY)) or
            (!m_tvalid ##1 (m_tvalid && (m_tuser == STAT_POPPED))))
    else $error("pop result missing or wrong");

endmodule

bind priority_min_heap_queue hpq_checker u_hpq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
